/* sv/matrix_vector_multiply_unit_macros.svh */
// Assertion macros shared by the matrix-vector multiply RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define MVM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* sv/mvm_pkg.sv */
// Shared types and constants for the matrix-vector multiply unit.
// No dependencies.
package mvm_pkg;

  localparam int unsigned VAL_W  = 16;  // Q8.8 element
  localparam int unsigned PROD_W = 32;  // Q16.16 product
  localparam int unsigned ACC_W  = 48;  // Q32.16 row sum
  localparam int unsigned IDX_W  = 10;  // row index field
  localparam int unsigned CFG_W  = 11;  // size registers
  localparam int unsigned CFG_AW = 1;   // register index

  localparam int unsigned MAX_COLS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF = 1024;
  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [CFG_AW-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_AW-1:0] REG_COLS = 1'b1;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_MATRIX = 1'b1
  } op_e;

  // Per-element tag that travels with a matrix element down the MAC pipe.
  typedef struct packed {
    logic             end_row;
    logic             last_row;
    logic [IDX_W-1:0] row_idx;
  } mac_tag_t;

  // Status from the MAC back to the front end.
  typedef struct packed {
    logic end_in_flight;  // row-ending element in the product stage
    logic out_full;       // result register holds an untaken request
  } mac_status_t;

endpackage

/* sv/mvm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mvm_mac.sv */
// Multiply-accumulate back end: product register, row accumulator, result register.
// Depends on mvm_pkg and the assertion macro header.
`include "matrix_vector_multiply_unit_macros.svh"

module mvm_mac
  import mvm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [VAL_W-1:0]  mat_i,
  input  logic signed [VAL_W-1:0]  vec_i,
  input  mac_tag_t                 tag_i,
  output mac_status_t              status_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ACC_W-1:0]  row_sum_o,
  output logic [IDX_W-1:0]         row_index_o,
  output logic                     last_row_o
);

  logic                     prod_valid_q;
  logic signed [PROD_W-1:0] prod_q;
  mac_tag_t                 prod_tag_q;
  logic [ACC_W-1:0]         acc_q;
  logic [ACC_W-1:0]         sum;
  logic                     out_valid_q;
  logic [ACC_W-1:0]         out_sum_q;
  logic [IDX_W-1:0]         out_idx_q;
  logic                     out_last_q;

  assign sum = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      prod_valid_q <= valid_i;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (prod_valid_q) begin
        if (prod_tag_q.end_row) begin
          // front end guarantees the result register is free here
          acc_q       <= '0;
          out_valid_q <= 1'b1;
        end else begin
          acc_q <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q     <= mat_i * vec_i;
      prod_tag_q <= tag_i;
    end
    if (prod_valid_q && prod_tag_q.end_row) begin
      out_sum_q  <= sum;
      out_idx_q  <= prod_tag_q.row_idx;
      out_last_q <= prod_tag_q.last_row;
    end
  end

  assign status_o.end_in_flight = prod_valid_q && prod_tag_q.end_row;
  assign status_o.out_full      = out_valid_q;
  assign out_valid_o = out_valid_q;
  assign row_sum_o   = out_sum_q;
  assign row_index_o = out_idx_q;
  assign last_row_o  = out_last_q;

  `MVM_ASSERT_NEVER(a_no_result_overwrite, prod_valid_q && prod_tag_q.end_row && out_valid_q,
                    "row sum would overwrite an untaken result")
  `MVM_ASSERT(a_result_from_row_end, $rose(out_valid_q) |-> $past(status_o.end_in_flight),
              "result appeared without a row-ending element")

endmodule

/* sv/matrix_vector_multiply_unit.sv */
// Matrix-vector multiply: vector RAM front end, element counters, MAC back end.
// A row's last element goes through the RAM read, product and result registers
// to row_sum_o. Throughput: one element per cycle within a row; after a row-ending
// element the input stalls until its result request is taken, set by the RAM read
// and product stages in front of the single result register.
// Reset clears counters, accumulator and valids; the vector RAM is not cleared.
`include "matrix_vector_multiply_unit_macros.svh"

module matrix_vector_multiply_unit
  import mvm_pkg::*;
#(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_AW-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  logic signed [VAL_W-1:0] element_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ACC_W-1:0] row_sum_o,
  output logic [IDX_W-1:0]        row_index_o,
  output logic                    last_row_o
);

  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned SZ_W  = $clog2(((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS) + 1);
  localparam int unsigned CMP_W = (CFG_W > SZ_W) ? CFG_W : SZ_W;

  logic [CFG_W-1:0] rows_q, cols_q;
  logic [CMP_W-1:0] rows_eff, cols_eff;
  logic [COL_W-1:0] ld_q, ld_d, ld_addr;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             accept, mat_acc, ld_acc;
  logic             end_row, last_row;
  logic             s1_valid_q;
  logic signed [VAL_W-1:0] s1_val_q;
  mac_tag_t         s1_tag_q;
  logic [VAL_W-1:0] vec_rdata;
  mac_status_t      mac_status;

  // register values of zero act as one, values above the maximum as the maximum
  always_comb begin
    if (rows_q == '0) begin
      rows_eff = CMP_W'(1);
    end else if (CMP_W'(rows_q) > CMP_W'(MAX_ROWS)) begin
      rows_eff = CMP_W'(MAX_ROWS);
    end else begin
      rows_eff = CMP_W'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = CMP_W'(1);
    end else if (CMP_W'(cols_q) > CMP_W'(MAX_COLS)) begin
      cols_eff = CMP_W'(MAX_COLS);
    end else begin
      cols_eff = CMP_W'(cols_q);
    end
  end

  assign in_stall_o = mac_status.out_full || mac_status.end_in_flight ||
                      (s1_valid_q && s1_tag_q.end_row);
  assign accept  = in_valid_i && !in_stall_o;
  assign mat_acc = accept && (operation_i == OP_MATRIX);
  assign ld_acc  = accept && (operation_i == OP_LOAD);

  always_comb begin
    ld_addr = (CMP_W'(ld_q) >= cols_eff) ? '0 : ld_q;
    ld_d    = (CMP_W'(ld_addr) + CMP_W'(1) >= cols_eff) ? '0 : COL_W'(ld_addr + 1'b1);
    end_row  = (CMP_W'(col_q) + CMP_W'(1) >= cols_eff);
    last_row = (CMP_W'(row_q) + CMP_W'(1) >= rows_eff);
    col_d    = end_row ? '0 : COL_W'(col_q + 1'b1);
    if (end_row) begin
      row_d = last_row ? '0 : ROW_W'(row_q + 1'b1);
    end else begin
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= SIZE_RESET;
      cols_q     <= SIZE_RESET;
      ld_q       <= '0;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ROWS: rows_q <= cfg_data_i;
          REG_COLS: cols_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ld_acc) begin
        ld_q <= ld_d;
      end
      if (mat_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      s1_valid_q <= mat_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_acc) begin
      s1_val_q         <= element_value_i;
      s1_tag_q.end_row  <= end_row;
      s1_tag_q.last_row <= end_row && last_row;
      s1_tag_q.row_idx  <= IDX_W'(row_q);
    end
  end

  // a load written at one edge is visible to a read issued at any later edge
  mvm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_COLS)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (ld_acc),
    .waddr_i (ld_addr),
    .wdata_i (element_value_i),
    .re_i    (mat_acc),
    .raddr_i (col_q),
    .rdata_o (vec_rdata)
  );

  mvm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid_q),
    .mat_i       (s1_val_q),
    .vec_i       (vec_rdata),
    .tag_i       (s1_tag_q),
    .status_o    (mac_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_sum_o   (row_sum_o),
    .row_index_o (row_index_o),
    .last_row_o  (last_row_o)
  );

  `MVM_ASSERT(a_row_end_blocks_input, (mat_acc && end_row) |=> in_stall_o,
              "input taken behind a row-ending element")
  `MVM_ASSERT(a_col_wraps_at_row_end, (mat_acc && end_row) |=> (col_q == '0),
              "column position did not return to zero at row end")
  `MVM_ASSERT_NEVER(a_no_accept_while_full, accept && mac_status.out_full,
                    "element accepted while a result request waits")

endmodule

/* bench/mvm_row_checker.sv */
// Row-sum checker for the matrix-vector multiply unit: tracks size writes, predicts row sums.
// Compares every accepted result against the oldest prediction. Depends on mvm_pkg.
`timescale 1ns / 100ps

module mvm_row_checker
  import mvm_pkg::*;
#(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_AW-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    operation_i,
  input  logic signed [VAL_W-1:0] element_value_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [ACC_W-1:0] row_sum_i,
  input  logic [IDX_W-1:0]        row_index_i,
  input  logic                    last_row_i,
  output int                      mismatches_o,
  output int                      pending_o,
  output int                      rows_checked_o
);

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic [IDX_W-1:0]        idx;
    logic                    last;
  } row_result_t;

  logic [VAL_W-1:0] vec_mem [MAX_COLS];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  logic [ACC_W-1:0] acc;
  int unsigned      load_pos;
  int unsigned      col_pos;
  int unsigned      row_pos;
  row_result_t      expected_rows [$];
  int               bad_rows;
  int               rows_checked;

  // zero acts as one, oversize acts as the maximum
  function automatic int unsigned size_in_use(logic [CFG_W-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  function automatic void note_mismatch(string msg);
    bad_rows++;
    if (bad_rows <= 10) $display("[%0t] row mismatch: %s", $realtime, msg);
  endfunction

  // one accepted request: vector load or multiply-accumulate of a matrix element
  function automatic void multiply_accumulate(op_e op, logic signed [VAL_W-1:0] v);
    int unsigned             rows;
    int unsigned             cols;
    int unsigned             p;
    int unsigned             col;
    logic signed [2*VAL_W-1:0] prod;
    row_result_t             r;
    rows = size_in_use(rows_reg, MAX_ROWS);
    cols = size_in_use(cols_reg, MAX_COLS);
    if (op == OP_LOAD) begin
      p = (load_pos >= cols) ? 0 : load_pos;
      vec_mem[p] = v;
      p++;
      load_pos = (p >= cols) ? 0 : p;
    end else begin
      col  = (col_pos < MAX_COLS) ? col_pos : MAX_COLS - 1;
      prod = v * $signed(vec_mem[col]);
      acc  = acc + {{(ACC_W-2*VAL_W){prod[2*VAL_W-1]}}, prod};
      if (col + 1 < cols) begin
        col_pos = col + 1;
      end else begin
        // a shrunken column count ends the row here, a shrunken row count ends the matrix
        r.sum  = acc;
        r.idx  = row_pos[IDX_W-1:0];
        r.last = (row_pos + 1 >= rows);
        expected_rows.push_back(r);
        acc     = '0;
        col_pos = 0;
        row_pos = r.last ? 0 : row_pos + 1;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    row_result_t want;
    if (!rst_ni) begin
      rows_reg     = SIZE_RESET;
      cols_reg     = SIZE_RESET;
      acc          = '0;
      load_pos     = 0;
      col_pos      = 0;
      row_pos      = 0;
      bad_rows     = 0;
      rows_checked = 0;
      expected_rows.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_ROWS) rows_reg = cfg_data_i;
        if (cfg_index_i == REG_COLS) cols_reg = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        rows_checked++;
        if (expected_rows.size() == 0) begin
          note_mismatch($sformatf("unexpected sum %0d row %0d last %0b",
                                  row_sum_i, row_index_i, last_row_i));
        end else begin
          want = expected_rows.pop_front();
          if (row_sum_i !== want.sum || row_index_i !== want.idx ||
              last_row_i !== want.last)
            note_mismatch($sformatf("expected sum %0d row %0d last %0b, got %0d row %0d last %0b",
                                    want.sum, want.idx, want.last,
                                    row_sum_i, row_index_i, last_row_i));
        end
      end
      if (in_valid_i && !in_stall_i) multiply_accumulate(op_e'(operation_i), element_value_i);
    end
    mismatches_o   <= bad_rows;
    pending_o      <= expected_rows.size();
    rows_checked_o <= rows_checked;
  end

endmodule

/* bench/matrix_vector_multiply_unit_tb.sv */
// Testbench top for the matrix-vector multiply unit: clock, reset, size writes, element stream.
// Depends on mvm_pkg, matrix_vector_multiply_unit and mvm_row_checker.
`timescale 1ns / 100ps

module matrix_vector_multiply_unit_tb;
  import mvm_pkg::*;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    cfg_we        = 1'b0;
  logic [CFG_AW-1:0]       cfg_index     = '0;
  logic [CFG_W-1:0]        cfg_data      = '0;
  logic                    in_valid      = 1'b0;
  logic                    operation     = 1'b0;
  logic signed [VAL_W-1:0] element_value = '0;
  logic                    out_stall     = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic signed [ACC_W-1:0] row_sum;
  logic [IDX_W-1:0]        row_index;
  logic                    last_row;

  int          mismatches;
  int          pending;
  int          rows_checked;
  bit          no_idle  = 1'b0;
  int unsigned rows_now = 32'(SIZE_RESET);
  int unsigned cols_now = 32'(SIZE_RESET);
  int          sent     = 0;
  int          phases   = 0;

  matrix_vector_multiply_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .element_value_i (element_value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .row_sum_o       (row_sum),
    .row_index_o     (row_index),
    .last_row_o      (last_row)
  );

  mvm_row_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .element_value_i (element_value),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .row_sum_i       (row_sum),
    .row_index_i     (row_index),
    .last_row_i      (last_row),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .rows_checked_o  (rows_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 34);
  end

  function automatic int unsigned size_in_use(logic [CFG_W-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      3:       return '1;
      default: return r[VAL_W-1:0];
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_size(bit allow_big);
    case ($urandom_range(19))
      0:       return '0;
      1:       return 11'd1;
      2:       return allow_big ? 11'd2047 : 11'd2;
      3:       return allow_big ? CFG_W'($urandom_range(1024, 2047)) : 11'd12;
      4, 5:    return CFG_W'($urandom_range(13, 24));
      default: return CFG_W'($urandom_range(1, 12));
    endcase
  endfunction

  // one request on the element channel, with random idle cycles in front
  task automatic send_element(input op_e op, input logic signed [VAL_W-1:0] v);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // drain all row sums, then leave room for elements still in the MAC pipe
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_sizes(input bit do_rows, input logic [CFG_W-1:0] r,
                           input bit do_cols, input logic [CFG_W-1:0] c);
    if (do_rows) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ROWS;
      cfg_data  <= r;
      rows_now   = size_in_use(r, MAX_ROWS_DEF);
      @(posedge clk);
    end
    if (do_cols) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_COLS;
      cfg_data  <= c;
      cols_now   = size_in_use(c, MAX_COLS_DEF);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    phases++;
  endtask

  // full vector load (so no unwritten entry is ever read), then the matrix stream;
  // matrix_items of zero picks a count from the sizes
  task automatic run_phase(input bit do_rows, input logic [CFG_W-1:0] r,
                           input bit do_cols, input logic [CFG_W-1:0] c,
                           input int unsigned extra_loads, input int unsigned matrix_items);
    int unsigned n;
    settle();
    set_sizes(do_rows, r, do_cols, c);
    n = matrix_items;
    if (n == 0) begin
      if (rows_now * cols_now <= 64 && $urandom_range(3) != 0)
        n = rows_now * cols_now * $urandom_range(1, 2) + $urandom_range(0, cols_now);
      else
        n = $urandom_range(1, 64);
    end
    repeat (cols_now + extra_loads) send_element(OP_LOAD, pick_value());
    repeat (n) begin
      if (!no_idle && $urandom_range(99) < 6) send_element(OP_LOAD, pick_value());
      send_element(OP_MATRIX, pick_value());
    end
  endtask

  initial begin
    int phase_no;
    int start;
    int rand_items;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 2x3 with extreme elements, then vector overrun and matrix wrap
    set_sizes(1'b1, 11'd2, 1'b1, 11'd3);
    send_element(OP_LOAD, 16'h7fff);
    send_element(OP_LOAD, 16'h8000);
    send_element(OP_LOAD, 16'h0001);
    send_element(OP_MATRIX, 16'h8000);
    send_element(OP_MATRIX, 16'h7fff);
    send_element(OP_MATRIX, 16'h0000);
    send_element(OP_MATRIX, 16'h7fff);
    send_element(OP_MATRIX, 16'h8000);
    send_element(OP_MATRIX, 16'hffff);
    send_element(OP_LOAD, 16'h5555);
    send_element(OP_LOAD, 16'hffff);
    send_element(OP_LOAD, 16'h0100);
    send_element(OP_LOAD, 16'h2aaa);
    send_element(OP_MATRIX, 16'hffff);
    send_element(OP_MATRIX, 16'h0001);
    send_element(OP_MATRIX, 16'h00ff);
    send_element(OP_MATRIX, 16'h7f00);
    // shrink both sizes mid-row: the next element ends the row and the matrix
    settle();
    set_sizes(1'b1, '0, 1'b1, 11'd1);
    send_element(OP_LOAD, 16'h1234);
    send_element(OP_MATRIX, 16'hc000);
    send_element(OP_MATRIX, 16'h0080);

    rand_items = 0;
    phase_no   = 0;
    while (rand_items < 300 || phase_no < 6) begin
      phase_no++;
      if (phase_no == 3) begin
        // long run of 40-column rows with no idling on either side
        no_idle = 1'b1;
        run_phase(1'b1, 11'd2047, 1'b1, 11'd40, 0, 160);
        no_idle = 1'b0;
      end else if (phase_no == 6) begin
        // single column, many one-element rows
        run_phase(1'b1, 11'd2047, 1'b1, 11'd1, 0, 40);
      end else begin
        start = sent;
        run_phase($urandom_range(1), pick_size(1'b1), 1'b1, pick_size(1'b0),
                  ($urandom_range(9) == 0) ? $urandom_range(1, 14) : 0, 0);
        rand_items += sent - start;
      end
    end

    settle();
    $display("covered %0d element requests over %0d size settings, %0d row sums checked",
             sent, phases, rows_checked);
    $display("included size clamping, vector overrun, mid-row size changes, row wrap");
    if (mismatches == 0 && pending == 0)
      $display("matrix_vector_multiply_unit regression: pass");
    else
      $display("matrix_vector_multiply_unit regression: fail");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout waiting for the element stream to drain");
    $display("matrix_vector_multiply_unit regression: fail");
    $finish;
  end

endmodule
